// File: rtl/core/ujesc_pkg.sv
// Package for the UTF-8 to JSON string escaper: character codes, run sizes
// and the hex digit lookup. No dependencies.
package ujesc_pkg;

  localparam int unsigned RunMax  = 13;  // surrogate pair escape + close quote
  localparam int unsigned BodyMax = 12;  // two backslash-u escapes
  localparam int unsigned RunLenW = $clog2(RunMax + 1);

  typedef logic [6:0] char_t;

  localparam char_t CH_QUOTE  = 7'h22;
  localparam char_t CH_BSLASH = 7'h5c;
  localparam char_t CH_LC_B   = 7'h62;
  localparam char_t CH_LC_F   = 7'h66;
  localparam char_t CH_LC_N   = 7'h6e;
  localparam char_t CH_LC_R   = 7'h72;
  localparam char_t CH_LC_T   = 7'h74;
  localparam char_t CH_LC_U   = 7'h75;
  localparam char_t CH_NUL    = 7'h00;
  localparam char_t CH_DEL    = 7'h7f;

  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_LF  = 8'h0a;
  localparam logic [7:0] BYTE_FF  = 8'h0c;
  localparam logic [7:0] BYTE_CR  = 8'h0d;

  localparam logic [15:0] SURR_HI_BASE = 16'hd800;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  // Lowercase hex digit for one nibble.
  function automatic char_t hex_char(input logic [3:0] nib);
    char_t c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h57 + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

// File: rtl/core/utf8_to_json_string_escaper_top.sv
// UTF-8 to JSON string escaper, top level.
// Depends on ujesc_pkg (character codes, hex lookup).
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one beat per raw byte of
//   a UTF-8 string, with first/last/empty string marks. Output channel
//   (out_valid_o / out_ready_i) carries one ASCII character of the quoted
//   JSON literal per beat; run_last_o marks the final beat caused by an
//   input byte, utf8_error_o a single error beat (character 0) that aborts
//   the string. The rest of an aborted string produces no beats.
//   Path: an accepted byte's characters are registered in the run buffer,
//   then move one at a time into the output register.
//   Throughput: a byte holds the run buffer until all of its characters have
//   moved on, so plain ASCII streams at one byte per cycle while the
//   receiver does not stall; escapes emit more characters (short form, \uXXXX,
//   surrogate pair), plus one per quote; bytes with no characters add none.
//   The next byte is accepted in the cycle the last character of the
//   current run moves into the output register, so the decoder never idles
//   behind a full output register with an empty run buffer.
//   Reset clears the decoder state, the run buffer length and the output valid.
//   When the receiver stalls, the output register holds its beat, the run
//   buffer holds, and in_ready_o drops once the buffer cannot drain.
module utf8_to_json_string_escaper_top
  import ujesc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       first_of_string_i,
  input  logic       last_of_string_i,
  input  logic       empty_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] out_char_o,
  output logic       run_last_o,
  output logic       utf8_error_o
);

  // Decoder state
  logic [20:0] acc_q, acc_d;
  logic [1:0]  rem_q, rem_d;
  logic        in_str_q, in_str_d;
  logic        skip_q, skip_d;

  // Run buffer: characters still to send for the current byte, head at 0
  char_t               run_chars_q [RunMax];
  char_t               run_chars_d [RunMax];
  logic [RunLenW-1:0]  run_len_q, run_len_d;
  logic                run_err_q, run_err_d;

  // Output register
  logic       out_valid_q;
  char_t      out_char_q;
  logic       out_last_q;
  logic       out_err_q;

  logic in_accept;
  logic out_load;

  assign out_load   = (run_len_q != '0) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (run_len_q == '0) ||
                      ((run_len_q == RunLenW'(1)) && out_load);
  assign in_accept  = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------
  // Decode one byte into a run of characters and the next decoder state.
  // ---------------------------------------------------------------------
  logic        restart;
  logic        eff_skip;
  logic [1:0]  eff_rem;
  logic [20:0] eff_acc;
  logic [20:0] acc_shift;
  logic [1:0]  rem_dec;
  logic [20:0] supp;
  logic [15:0] u_hi, u_lo;
  logic        open_q_c, close_q_c, err_c, empty_c;
  char_t       body [BodyMax];
  logic [3:0]  body_len;
  logic [1:0]  lead_cnt;
  char_t       new_chars [RunMax];
  logic [RunLenW-1:0] new_len;
  logic [3:0]  j;

  assign restart   = first_of_string_i || !in_str_q;
  assign eff_skip  = restart ? 1'b0  : skip_q;
  assign eff_rem   = restart ? 2'b00 : rem_q;
  assign eff_acc   = restart ? '0    : acc_q;
  assign acc_shift = {eff_acc[14:0], text_byte_i[5:0]};
  assign rem_dec   = eff_rem - 2'd1;
  assign supp      = acc_shift - SUPP_BASE;

  always_comb begin
    acc_d     = acc_q;
    rem_d     = rem_q;
    in_str_d  = in_str_q;
    skip_d    = skip_q;
    open_q_c  = 1'b0;
    close_q_c = 1'b0;
    err_c     = 1'b0;
    empty_c   = 1'b0;
    body_len  = 4'd0;
    lead_cnt  = 2'd0;
    u_hi      = {8'h00, text_byte_i};
    u_lo      = '0;
    for (int i = 0; i < BodyMax; i++) begin
      body[i] = CH_NUL;
    end

    if (empty_string_i) begin
      empty_c  = 1'b1;
      acc_d    = '0;
      rem_d    = '0;
      in_str_d = 1'b0;
      skip_d   = 1'b0;
    end else begin
      if (restart) begin
        open_q_c = 1'b1;
        acc_d    = '0;
        rem_d    = '0;
        skip_d   = 1'b0;
        in_str_d = 1'b1;
      end

      if (eff_skip) begin
        // Drop bytes of an aborted string until its end
        if (last_of_string_i) begin
          in_str_d = 1'b0;
          skip_d   = 1'b0;
        end
      end else if (eff_rem == 2'd0) begin
        if (!text_byte_i[7]) begin
          body[0]  = CH_BSLASH;
          body_len = 4'd2;
          priority if (text_byte_i[6:0] == CH_QUOTE || text_byte_i[6:0] == CH_BSLASH) begin
            body[1] = text_byte_i[6:0];
          end else if (text_byte_i == BYTE_BS) begin
            body[1] = CH_LC_B;
          end else if (text_byte_i == BYTE_FF) begin
            body[1] = CH_LC_F;
          end else if (text_byte_i == BYTE_LF) begin
            body[1] = CH_LC_N;
          end else if (text_byte_i == BYTE_CR) begin
            body[1] = CH_LC_R;
          end else if (text_byte_i == BYTE_TAB) begin
            body[1] = CH_LC_T;
          end else if (text_byte_i[6:5] == 2'b00 || text_byte_i[6:0] == CH_DEL) begin
            body[1]  = CH_LC_U;
            body[2]  = hex_char(u_hi[15:12]);
            body[3]  = hex_char(u_hi[11:8]);
            body[4]  = hex_char(u_hi[7:4]);
            body[5]  = hex_char(u_hi[3:0]);
            body_len = 4'd6;
          end else begin
            body[0]  = text_byte_i[6:0];
            body_len = 4'd1;
          end
        end else begin
          priority if (text_byte_i[7:5] == 3'b110) begin
            lead_cnt = 2'd1;
            acc_d    = {16'h0000, text_byte_i[4:0]};
          end else if (text_byte_i[7:4] == 4'b1110) begin
            lead_cnt = 2'd2;
            acc_d    = {17'h00000, text_byte_i[3:0]};
          end else if (text_byte_i[7:3] == 5'b11110) begin
            lead_cnt = 2'd3;
            acc_d    = {18'h00000, text_byte_i[2:0]};
          end else begin
            lead_cnt = 2'd0;
          end
          if (lead_cnt == 2'd0 || last_of_string_i) begin
            err_c = 1'b1;
          end else begin
            rem_d = lead_cnt;
          end
        end
      end else begin
        if (text_byte_i[7:6] != 2'b10) begin
          err_c = 1'b1;
        end else begin
          acc_d = acc_shift;
          rem_d = rem_dec;
          if (rem_dec == 2'd0) begin
            acc_d   = '0;
            body[0] = CH_BSLASH;
            body[1] = CH_LC_U;
            if (acc_shift[20:16] == 5'd0) begin
              u_hi     = acc_shift[15:0];
              body_len = 4'd6;
            end else begin
              u_hi      = SURR_HI_BASE + {5'd0, supp[20:10]};
              u_lo      = {6'b110111, supp[9:0]};
              body[6]   = CH_BSLASH;
              body[7]   = CH_LC_U;
              body[8]   = hex_char(u_lo[15:12]);
              body[9]   = hex_char(u_lo[11:8]);
              body[10]  = hex_char(u_lo[7:4]);
              body[11]  = hex_char(u_lo[3:0]);
              body_len  = 4'd12;
            end
            body[2] = hex_char(u_hi[15:12]);
            body[3] = hex_char(u_hi[11:8]);
            body[4] = hex_char(u_hi[7:4]);
            body[5] = hex_char(u_hi[3:0]);
          end else if (last_of_string_i) begin
            err_c = 1'b1;
          end
        end
      end

      if (err_c) begin
        acc_d = '0;
        rem_d = '0;
        if (last_of_string_i) begin
          in_str_d = 1'b0;
          skip_d   = 1'b0;
        end else begin
          skip_d = 1'b1;
        end
      end else if (last_of_string_i && !eff_skip) begin
        close_q_c = 1'b1;
        acc_d     = '0;
        rem_d     = '0;
        in_str_d  = 1'b0;
        skip_d    = 1'b0;
      end
    end
  end

  // Run: [opening quote] body [closing quote]; NUL on error; two quotes if empty
  always_comb begin
    j = 4'd0;
    for (int i = 0; i < RunMax; i++) begin
      j = 4'(i) - {3'b000, open_q_c};
      if (empty_c || err_c) begin
        new_chars[i] = (err_c) ? CH_NUL : CH_QUOTE;
      end else if (open_q_c && i == 0) begin
        new_chars[i] = CH_QUOTE;
      end else if (j < body_len) begin
        new_chars[i] = body[j];
      end else begin
        new_chars[i] = CH_QUOTE;
      end
    end
    if (empty_c) begin
      new_len = RunLenW'(2);
    end else if (err_c) begin
      new_len = RunLenW'(1);
    end else if (eff_skip) begin
      new_len = '0;
    end else begin
      new_len = RunLenW'(body_len) + RunLenW'(open_q_c) + RunLenW'(close_q_c);
    end
  end

  // Run buffer next value: load on accept, else shift toward the head on an output load
  always_comb begin
    run_len_d = run_len_q;
    run_err_d = run_err_q;
    for (int i = 0; i < RunMax; i++) begin
      run_chars_d[i] = run_chars_q[i];
    end
    if (in_accept) begin
      run_len_d = new_len;
      run_err_d = err_c;
      for (int i = 0; i < RunMax; i++) begin
        run_chars_d[i] = new_chars[i];
      end
    end else if (out_load) begin
      run_len_d = run_len_q - RunLenW'(1);
      for (int i = 0; i < RunMax - 1; i++) begin
        run_chars_d[i] = run_chars_q[i + 1];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      rem_q       <= '0;
      in_str_q    <= 1'b0;
      skip_q      <= 1'b0;
      run_len_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        acc_q    <= acc_d;
        rem_q    <= rem_d;
        in_str_q <= in_str_d;
        skip_q   <= skip_d;
      end
      run_len_q <= run_len_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: run buffer contents and the output beat
  always_ff @(posedge clk_i) begin
    run_err_q <= run_err_d;
    for (int i = 0; i < RunMax; i++) begin
      run_chars_q[i] <= run_chars_d[i];
    end
    if (out_load) begin
      out_char_q <= run_chars_q[0];
      out_last_q <= (run_len_q == RunLenW'(1));
      out_err_q  <= run_err_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign run_last_o   = out_last_q;
  assign utf8_error_o = out_err_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_err_beat_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && utf8_error_o |-> run_last_o && (out_char_o == CH_NUL))
    else $error("error beat is not a lone NUL run end");

  a_run_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_len_q <= RunLenW'(RunMax))
    else $error("run buffer length out of range");

  a_backlog_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_len_q != '0) && !out_valid_q |=> out_valid_q)
    else $error("pending run did not reach the output register");

  a_mid_run_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> (run_len_q != '0) && !in_accept ||
    (run_len_q != '0))
    else $error("run ended without its last beat");

endmodule

// File: bench/utf8_to_json_string_escaper_top_tb.sv
// Testbench for utf8_to_json_string_escaper_top: drives UTF-8 byte beats,
// predicts every escaped character beat and checks the output stream.
// Depends on ujesc_pkg and the escaper RTL only.
`timescale 1ns / 100ps

module utf8_to_json_string_escaper_top_tb
  import ujesc_pkg::*;
();

  localparam logic [15:0] SURR_LO_BASE = 16'hdc00;
  localparam int unsigned DRAIN_CYCLES = 20;

  // One expected output beat.
  typedef struct packed {
    char_t ch;
    logic  run_last;
    logic  err;
  } esc_beat_t;

  // Ways a random string gets broken.
  typedef enum int unsigned {
    FLAW_NONE,
    FLAW_STRAY_BYTE,
    FLAW_BAD_LEAD,
    FLAW_CUT_SHORT,
    FLAW_BAD_CONT,
    FLAW_NO_FIRST,
    FLAW_NO_LAST
  } flaw_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] text_byte = 8'h00;
  logic       first_of_string = 1'b0;
  logic       last_of_string = 1'b0;
  logic       empty_string = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_char;
  logic       run_last;
  logic       utf8_error;

  // Escaper state as predicted
  logic [20:0] cp_acc;
  logic [1:0]  cont_left;
  logic        str_open;
  logic        dropping;

  esc_beat_t   pending_chars[$];   // characters still owed by the block
  esc_beat_t   run_chars[$];       // characters of the byte being escaped
  logic [7:0]  str_bytes[$];       // bytes of the random string being built

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned mismatches = 0;

  utf8_to_json_string_escaper_top dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .text_byte_i       (text_byte),
    .first_of_string_i (first_of_string),
    .last_of_string_i  (last_of_string),
    .empty_string_i    (empty_string),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .out_char_o        (out_char),
    .run_last_o        (run_last),
    .utf8_error_o      (utf8_error)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: stall at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Return the decoder to idle, as reset and string ends do.
  task automatic clear_decoder();
    cp_acc    = '0;
    cont_left = '0;
    str_open  = 1'b0;
    dropping  = 1'b0;
  endtask

  task automatic add_char(input char_t c);
    esc_beat_t beat;
    beat = '{ch: c, run_last: 1'b0, err: 1'b0};
    run_chars.insert(run_chars.size(), beat);
  endtask

  // Emit backslash-u and four lowercase hex digits, high nibble first.
  task automatic add_uescape(input logic [15:0] v);
    logic [3:0] nib;
    add_char(CH_BSLASH);
    add_char(CH_LC_U);
    for (int k = 3; k >= 0; k--) begin
      nib = v[4*k +: 4];
      add_char((nib > 4'd9) ? 7'h61 + 7'(nib) - 7'd10 : 7'h30 + 7'(nib));
    end
  endtask

  // Advance the predicted state by one accepted byte and queue the characters
  // that byte must produce.
  task automatic escape_byte(input logic [7:0] b, input logic first, input logic last,
                             input logic empty);
    logic        bad;
    logic [20:0] off;
    esc_beat_t   tail;
    esc_beat_t   err_beat;
    bad = 1'b0;
    run_chars.delete();
    if (empty) begin
      // Zero-length string: the byte and the other flags do not matter.
      clear_decoder();
      add_char(CH_QUOTE);
      add_char(CH_QUOTE);
    end else begin
      // A first mark, or any byte while no string is open, starts a new one
      // and throws away whatever the old one left unfinished.
      if (first || !str_open) begin
        clear_decoder();
        str_open = 1'b1;
        add_char(CH_QUOTE);
      end
      if (dropping) begin
        // Rest of an aborted string: silent, last mark closes it.
        if (last) clear_decoder();
      end else begin
        if (cont_left == 2'd0) begin
          if (!b[7]) begin
            case (b)
              {1'b0, CH_QUOTE}, {1'b0, CH_BSLASH}: begin
                add_char(CH_BSLASH);
                add_char(b[6:0]);
              end
              BYTE_BS:  begin add_char(CH_BSLASH); add_char(CH_LC_B); end
              BYTE_FF:  begin add_char(CH_BSLASH); add_char(CH_LC_F); end
              BYTE_LF:  begin add_char(CH_BSLASH); add_char(CH_LC_N); end
              BYTE_CR:  begin add_char(CH_BSLASH); add_char(CH_LC_R); end
              BYTE_TAB: begin add_char(CH_BSLASH); add_char(CH_LC_T); end
              default: begin
                if (b < 8'h20 || b == {1'b0, CH_DEL}) add_uescape({8'h00, b});
                else add_char(b[6:0]);
              end
            endcase
          end else if (last) begin
            // A lead byte cannot end a string, valid or not.
            bad = 1'b1;
          end else if (b[7:5] == 3'b110) begin
            cp_acc    = {16'd0, b[4:0]};
            cont_left = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            cp_acc    = {17'd0, b[3:0]};
            cont_left = 2'd2;
          end else if (b[7:3] == 5'b11110) begin
            cp_acc    = {18'd0, b[2:0]};
            cont_left = 2'd3;
          end else begin
            bad = 1'b1;
          end
        end else if (b[7:6] != 2'b10) begin
          bad = 1'b1;
        end else begin
          cp_acc    = {cp_acc[14:0], b[5:0]};
          cont_left = cont_left - 2'd1;
          if (cont_left == 2'd0) begin
            if (cp_acc <= 21'h00ffff) begin
              add_uescape(cp_acc[15:0]);
            end else begin
              // Beyond the basic plane: split into a surrogate pair.
              off = cp_acc - SUPP_BASE;
              add_uescape(SURR_HI_BASE + {5'd0, off[20:10]});
              add_uescape(SURR_LO_BASE + {6'd0, off[9:0]});
            end
            cp_acc = '0;
          end else if (last) begin
            bad = 1'b1;
          end
        end

        if (bad) begin
          // Error replaces everything this byte would emit, quote included.
          run_chars.delete();
          err_beat = '{ch: CH_NUL, run_last: 1'b1, err: 1'b1};
          run_chars.insert(run_chars.size(), err_beat);
          cp_acc    = '0;
          cont_left = '0;
          if (last) clear_decoder();
          else dropping = 1'b1;
        end else if (last) begin
          add_char(CH_QUOTE);
          clear_decoder();
        end
      end
    end

    if (run_chars.size() != 0) begin
      tail = run_chars[run_chars.size() - 1];
      tail.run_last = 1'b1;
      run_chars[run_chars.size() - 1] = tail;
    end
    foreach (run_chars[i]) pending_chars.insert(pending_chars.size(), run_chars[i]);
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_beat(input string why, input esc_beat_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: got char %02h last %b err %b, want char %02h last %b err %b",
               $realtime, why, out_char, run_last, utf8_error,
               want.ch, want.run_last, want.err);
    end
  endtask

  // Compare every output beat with the oldest character owed.
  always @(posedge clk) begin : check_beats
    esc_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        report_beat("beat with nothing expected", '0);
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.ch || run_last !== want.run_last ||
            utf8_error !== want.err) begin
          report_beat("beat mismatch", want);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Send one byte beat. Idle first at the phase rate, then hold valid and the
  // payload until the block takes the beat. Valid stays high when the next
  // beat follows without a gap.
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                           input logic empty);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    text_byte       <= b;
    first_of_string <= first;
    last_of_string  <= last;
    empty_string    <= empty;
    do @(posedge clk); while (!in_ready);
    escape_byte(b, first, last, empty);
    bytes_sent++;
  endtask

  // Append one byte to the string being built.
  task automatic append_byte(input logic [7:0] b);
    str_bytes.insert(str_bytes.size(), b);
  endtask

  function automatic logic [7:0] lead_byte(input int unsigned n_cont);
    case (n_cont)
      1:       return {3'b110, 5'($urandom)};
      2:       return {4'b1110, 4'($urandom)};
      default: return {5'b11110, 3'($urandom)};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // Append one character: plain ASCII, something that needs escaping, or a
  // well-formed multi-byte sequence with random payload bits. Overlong and
  // out-of-range code points come along for free.
  task automatic add_random_char();
    int unsigned n_cont;
    case ($urandom_range(9))
      0, 1, 2, 3: append_byte(8'($urandom_range(32, 126)));
      4:          append_byte(8'($urandom_range(31)));
      5: begin
        case ($urandom_range(2))
          0:       append_byte({1'b0, CH_QUOTE});
          1:       append_byte({1'b0, CH_BSLASH});
          default: append_byte({1'b0, CH_DEL});
        endcase
      end
      default: begin
        n_cont = $urandom_range(1, 3);
        append_byte(lead_byte(n_cont));
        repeat (n_cont) append_byte(cont_byte());
      end
    endcase
  endtask

  // Build and send one string. Most are well formed; about one in five is
  // broken in some way, and a few are empty strings.
  task automatic send_random_string();
    int unsigned n_chars;
    int unsigned n_cont;
    int unsigned n_bytes;
    flaw_e       flaw;
    logic [7:0]  junk;
    str_bytes.delete();
    if ($urandom_range(19) == 0) begin
      send_byte(8'($urandom_range(255)), 1'($urandom), 1'($urandom), 1'b1);
    end else begin
      n_chars = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
      repeat (n_chars) add_random_char();
      flaw = FLAW_NONE;
      if ($urandom_range(4) == 0) flaw = flaw_e'($urandom_range(FLAW_STRAY_BYTE, FLAW_NO_LAST));
      case (flaw)
        FLAW_STRAY_BYTE: begin
          str_bytes.insert($urandom_range(str_bytes.size() - 1), 8'($urandom_range(255)));
        end
        FLAW_BAD_LEAD: begin
          junk = ($urandom_range(1) == 0) ? 8'($urandom_range(128, 191))
                                          : 8'($urandom_range(248, 255));
          str_bytes.insert($urandom_range(str_bytes.size() - 1), junk);
        end
        FLAW_CUT_SHORT: begin
          // Sequence left unfinished by the end of the string.
          n_cont = $urandom_range(1, 3);
          append_byte(lead_byte(n_cont));
          repeat ($urandom_range(n_cont - 1)) append_byte(cont_byte());
        end
        FLAW_BAD_CONT: begin
          n_cont = $urandom_range(1, 3);
          append_byte(lead_byte(n_cont));
          repeat ($urandom_range(n_cont - 1)) append_byte(cont_byte());
          junk = 8'($urandom_range(255));
          if (junk[7:6] == 2'b10) junk[6] = 1'b1;
          append_byte(junk);
          repeat ($urandom_range(2)) add_random_char();
        end
        default: ;
      endcase
      n_bytes = str_bytes.size();
      foreach (str_bytes[i]) begin
        send_byte(str_bytes[i], i == 0 && flaw != FLAW_NO_FIRST,
                  i == n_bytes - 1 && flaw != FLAW_NO_LAST, 1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // One string through the ASCII escapes: lowest byte, every short form,
  // quote, backslash, plain space, and DEL at the top.
  task automatic test_ascii_escapes();
    logic [7:0] probe[10] = '{8'h00, BYTE_BS, BYTE_TAB, BYTE_LF, BYTE_FF, BYTE_CR,
                              {1'b0, CH_QUOTE}, {1'b0, CH_BSLASH}, 8'h20,
                              {1'b0, CH_DEL}};
    foreach (probe[i]) send_byte(probe[i], i == 0, i == 9, 1'b0);
  endtask

  // Two-byte sequence, then the largest four-byte pattern, which lands in a
  // surrogate pair far above the legal range.
  task automatic test_multibyte();
    send_byte(8'hc2, 1'b1, 1'b0, 1'b0);
    send_byte(8'ha9, 1'b0, 1'b0, 1'b0);
    send_byte(8'hf7, 1'b0, 1'b0, 1'b0);
    send_byte(8'hbf, 1'b0, 1'b0, 1'b0);
    send_byte(8'hbf, 1'b0, 1'b0, 1'b0);
    send_byte(8'hbf, 1'b0, 1'b1, 1'b0);
  endtask

  // Bad lead byte with the rest of the string dropped, a non-continuation
  // byte leaving the string open, then a string cut off mid-sequence.
  task automatic test_bad_utf8();
    send_byte(8'hff, 1'b1, 1'b0, 1'b0);
    send_byte(8'h41, 1'b0, 1'b1, 1'b0);
    send_byte(8'hc3, 1'b1, 1'b0, 1'b0);
    send_byte(8'h41, 1'b0, 1'b0, 1'b0);
    send_byte(8'he2, 1'b1, 1'b0, 1'b0);
    send_byte(8'h82, 1'b0, 1'b1, 1'b0);
  endtask

  // Byte with no string open, a new string cutting the open one off, and an
  // empty string carrying junk in its other fields.
  task automatic test_string_framing();
    send_byte(8'h78, 1'b0, 1'b0, 1'b0);
    send_byte(8'h79, 1'b1, 1'b1, 1'b0);
    send_byte(8'hff, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_random_strings(input int unsigned budget, input int unsigned send_idle,
                                     input int unsigned recv_stall);
    int unsigned start;
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
    start = bytes_sent;
    while (bytes_sent - start < budget) send_random_string();
  endtask

  initial begin
    clear_decoder();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ascii_escapes();
    test_multibyte();
    test_bad_utf8();
    test_string_framing();

    // Random strings under each idling mix.
    test_random_strings(100, 0, 0);
    test_random_strings(100, 87, 0);
    test_random_strings(100, 0, 87);
    test_random_strings(100, 16, 16);

    // Drop valid once the last beat is in, then let the output drain.
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ujesc_pkg.sv
rtl/core/utf8_to_json_string_escaper_top.sv
bench/utf8_to_json_string_escaper_top_tb.sv
